// ===== sv/tlf_pkg.sv =====
// ============================================================================
// tlf_pkg: shared types and constants of the text line framer
// Field widths, character codes and the command format that passes from the
// front end to the back end through the command queue.
// ============================================================================
package tlf_pkg;

    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int IDX_W   = 6;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;

    localparam logic [BYTE_W-1:0]  PRINT_LOW   = 8'h20;
    localparam logic [BYTE_W-1:0]  PRINT_HIGH  = 8'h7E;
    localparam logic [BYTE_W-1:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [BYTE_W-1:0]  CH_RETURN   = 8'h0D;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd20;

    // Depth of the command queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Command kinds: write one character into the line store, or play out a
    // completed line of the given length.
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_EMIT  = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

endpackage

// ===== sv/text_line_framer_with_stale_timeout.sv =====
// Throughput: one input byte per cycle while the command queue has room.
// A line end plays the line out character by character. The line RAM read is
// registered; a read waits for the last to reach the output. With the back end
// idle, a line end passes the queue, the emit state and the RAM read register
// before its first character is valid. Reset clears the fill count, the last
// arrival time, the queue and the output; the stale limit returns to 20 ms.
// ============================================================================
// text_line_framer_with_stale_timeout: assembles serial bytes into text lines
// Bytes arrive with a millisecond timestamp; printable bytes build a line,
// a newline or carriage return plays the line out character by character.
// ============================================================================
module text_line_framer_with_stale_timeout
    import tlf_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // Stale limit register, in milliseconds.
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    // Input channel: one received byte per transaction.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic [TIME_W-1:0]  now_ms,
    // Output channel: one character of a completed line per transaction.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAR_W-1:0]  line_char,
    output logic [IDX_W-1:0]   char_index,
    output logic               line_end
);

    // The command word carries a kind bit, a character and a count that is
    // either the store address or the length of a completed line.
    localparam int CNT_W = $clog2(LINE_BUFFER_SIZE);
    localparam int Q_W   = 1 + CHAR_W + CNT_W;

    logic           q_push;
    logic [Q_W-1:0] q_push_data;
    logic           q_full;
    logic           q_pop;
    logic           q_not_empty;
    logic [Q_W-1:0] q_pop_data;

    // The front end decides everything about a byte in the cycle it is
    // accepted: the stale check, the fill count update and which command,
    // if any, the byte produces.
    tlf_front #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .now_ms    (now_ms),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // Commands run in order, so stores for a new line never overtake the
    // play-out of the previous one that still reads the same RAM entries.
    tlf_cmd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // The back end owns the line RAM and the output register.
    tlf_back #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_char   (line_char),
        .char_index  (char_index),
        .line_end    (line_end)
    );

endmodule

// ===== sv/tlf_ram.sv =====
// ============================================================================
// tlf_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tlf_cmd_queue.sv =====
// ============================================================================
// tlf_cmd_queue: short command queue
// A small register FIFO that lets the front end and the back end stall
// independently of each other.
// ============================================================================
module tlf_cmd_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/tlf_front.sv =====
// ============================================================================
// tlf_front: byte classifier and line bookkeeping
// Accepts one byte per transaction, applies the stale timeout, tracks the
// fill count and issues store or play-out commands to the queue.
// ============================================================================
module tlf_front
    import tlf_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [LIMIT_W-1:0]                          cfg_wdata,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [BYTE_W-1:0]                           rx_byte,
    input  logic [TIME_W-1:0]                           now_ms,
    input  logic                                        q_full,
    output logic                                        q_push,
    output logic [1 + CHAR_W + $clog2(LINE_BUFFER_SIZE) - 1:0] q_data
);

    localparam int CAP   = LINE_BUFFER_SIZE - 1;
    localparam int CNT_W = $clog2(LINE_BUFFER_SIZE);

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   fill_reg,  fill_next;
    logic [TIME_W-1:0]  last_reg;
    logic [TIME_W-1:0]  gap;
    logic [CNT_W-1:0]   fill_eff;
    logic               accept;
    logic               is_eol;
    logic               is_print;
    cmd_kind_t          kind;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Wrapping difference against the previous arrival time.
    assign gap      = now_ms - last_reg;
    assign fill_eff = ((fill_reg != '0) && (gap > TIME_W'(limit_reg))) ? '0 : fill_reg;
    assign is_eol   = (rx_byte == CH_NEWLINE) || (rx_byte == CH_RETURN);
    assign is_print = rx_byte inside {[PRINT_LOW:PRINT_HIGH]};

    always_comb
    begin
        fill_next = fill_reg;
        q_push    = 1'b0;
        kind      = CMD_STORE;
        if (accept)
        begin
            fill_next = fill_eff;
            if (is_eol)
            begin
                kind      = CMD_EMIT;
                q_push    = (fill_eff != '0);
                fill_next = '0;
            end
            else if (is_print)
            begin
                if (fill_eff < CNT_W'(CAP))
                begin
                    q_push    = 1'b1;
                    fill_next = fill_eff + CNT_W'(1);
                end
                else
                begin
                    // Overrun drops the whole line.
                    fill_next = '0;
                end
            end
        end
    end

    // For a store the count field is the write address, for a play-out it is
    // the line length.
    assign q_data = {kind, rx_byte[CHAR_W-1:0], fill_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            fill_reg  <= '0;
            last_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            if (accept)
            begin
                last_reg <= now_ms;
            end
        end
    end

endmodule

// ===== sv/tlf_back.sv =====
// ============================================================================
// tlf_back: line store writer and line play-out
// Executes queued commands in order: stores characters into the line RAM and
// reads a completed line back out, one character per output transaction.
// ============================================================================
module tlf_back
    import tlf_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_not_empty,
    input  logic [1 + CHAR_W + $clog2(LINE_BUFFER_SIZE) - 1:0] q_data,
    output logic                                        q_pop,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic [CHAR_W-1:0]                           line_char,
    output logic [IDX_W-1:0]                            char_index,
    output logic                                        line_end
);

    localparam int CAP    = LINE_BUFFER_SIZE - 1;
    localparam int CNT_W  = $clog2(LINE_BUFFER_SIZE);
    localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int Q_W    = 1 + CHAR_W + CNT_W;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rd_pend_reg;
    logic [CNT_W-1:0]  pend_idx_reg;
    logic              pend_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              end_reg;

    cmd_kind_t         cmd_kind;
    logic [CHAR_W-1:0] cmd_char;
    logic [CNT_W-1:0]  cmd_cnt;
    logic              slot_free;
    logic              rd_last;
    logic              ram_we;
    logic              ram_re;
    logic [CHAR_W-1:0] ram_rdata;

    assign cmd_kind = cmd_kind_t'(q_data[Q_W-1]);
    assign cmd_char = q_data[Q_W-2 -: CHAR_W];
    assign cmd_cnt  = q_data[CNT_W-1:0];

    // A read may go out only when the output register is sure to be free
    // in the next cycle, when its data arrives.
    assign slot_free = !rd_pend_reg && (!out_valid_reg || !out_stall);
    assign rd_last   = (rd_idx_reg == len_reg - CNT_W'(1));

    always_comb
    begin
        q_pop  = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop  = q_not_empty;
                ram_we = q_not_empty && (cmd_kind == CMD_STORE);
            end
            BK_EMIT:
            begin
                ram_re = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty && (cmd_kind == CMD_EMIT))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free && rd_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid_next = rd_pend_reg || (out_valid_reg && out_stall);

    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAP)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd_cnt[ADDR_W-1:0]),
        .wdata (cmd_char),
        .re    (ram_re),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= ram_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (cmd_kind == CMD_EMIT))
        begin
            len_reg    <= cmd_cnt;
            rd_idx_reg <= '0;
        end
        else if (ram_re)
        begin
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
        end
        if (ram_re)
        begin
            pend_idx_reg  <= rd_idx_reg;
            pend_last_reg <= rd_last;
        end
        if (rd_pend_reg)
        begin
            char_reg  <= ram_rdata;
            index_reg <= IDX_W'(pend_idx_reg);
            end_reg   <= pend_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_char  = char_reg;
    assign char_index = index_reg;
    assign line_end   = end_reg;

endmodule

// ===== test/text_line_framer_with_stale_timeout_test.sv =====
// ============================================================================
// text_line_framer_with_stale_timeout_test: self-checking bench of the framer
// Sends timestamped serial bytes and compares every emitted character with a
// line assembler model kept in this bench. A directed script comes first, then
// random traffic in several phases, each with its own stale limit.
// ============================================================================
module text_line_framer_with_stale_timeout_test
    import tlf_pkg::*;
();

    localparam int LINE_CAP    = 63;
    localparam int PHASES      = 7;
    localparam int PHASE_BYTES = 24;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } char_slot_t;

    // One row of the directed script. A row with a repeat count sends its
    // byte value plus the repeat number, so long lines carry varied text.
    // Rows marked typed hold the single character that the line must give.
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic [TIME_W-1:0] at_ms;
        logic [6:0]        reps;
        logic              typed;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  ix;
        logic              last;
    } stim_row_t;

    localparam int ROWS = 23;

    stim_row_t script [ROWS] = '{
        '{8'h41, 32'd5,          7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h0A, 32'd25,         7'd1,  1'b1, 7'h41, 6'd0, 1'b1}, // gap equals limit
        '{8'h0D, 32'd30,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0}, // empty line
        '{8'h20, 32'd30,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h7E, 32'd30,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h1F, 32'd35,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h7F, 32'd55,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'hFF, 32'd75,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h00, 32'd95,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h0D, 32'd115,        7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h42, 32'd200,        7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h43, 32'd221,        7'd1,  1'b0, 7'h00, 6'd0, 1'b0}, // stale by one
        '{8'h0A, 32'd221,        7'd1,  1'b1, 7'h43, 6'd0, 1'b1},
        '{8'h44, 32'hFFFF_FFF0,  7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h45, 32'h0000_0004,  7'd1,  1'b0, 7'h00, 6'd0, 1'b0}, // wraps
        '{8'h0A, 32'h0000_0004,  7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h30, 32'd10,         7'd63, 1'b0, 7'h00, 6'd0, 1'b0}, // full line
        '{8'h0A, 32'd10,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h21, 32'd10,         7'd63, 1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h7E, 32'd10,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0}, // overrun
        '{8'h0A, 32'd10,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h5A, 32'd10,         7'd1,  1'b0, 7'h00, 6'd0, 1'b0},
        '{8'h0D, 32'd10,         7'd1,  1'b1, 7'h5A, 6'd0, 1'b1}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte   = '0;
    logic [TIME_W-1:0]  now_ms    = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CHAR_W-1:0]  line_char;
    logic [IDX_W-1:0]   char_index;
    logic               line_end;

    // Line assembler model state.
    logic [CHAR_W-1:0]  line_buf [LINE_CAP];
    int                 held = 0;
    logic [TIME_W-1:0]  last_arrival = '0;
    logic [LIMIT_W-1:0] limit_ms = LIMIT_RESET;

    char_slot_t         pending_chars [$];
    int                 chars_predicted = 0;
    int                 bytes_sent = 0;
    int                 fail_count = 0;
    bit                 steady = 1'b0;
    int                 hold_requests = 0;
    logic [TIME_W-1:0]  clock_ms = '0;

    text_line_framer_with_stale_timeout dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_char  (line_char),
        .char_index (char_index),
        .line_end   (line_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one accepted byte to the model and queues the characters that
    // a completed line produces.
    function automatic void frame_byte(input logic [BYTE_W-1:0] b,
                                       input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] gap;
        char_slot_t        slot;
        gap = t - last_arrival;
        // The stale check runs on every byte, dropped ones included.
        if (held > 0 && gap > {16'd0, limit_ms})
            held = 0;
        last_arrival = t;
        if (b == CH_NEWLINE || b == CH_RETURN)
        begin
            for (int k = 0; k < held; k++)
            begin
                slot.ch   = line_buf[k];
                slot.idx  = k[IDX_W-1:0];
                slot.last = (k == held - 1);
                pending_chars.push_back(slot);
                chars_predicted++;
            end
            held = 0;
        end
        else if (b >= PRINT_LOW && b <= PRINT_HIGH)
        begin
            if (held < LINE_CAP)
            begin
                line_buf[held] = b[CHAR_W-1:0];
                held++;
            end
            else
            begin
                // A printable byte into a full buffer throws the line away.
                held = 0;
            end
        end
    endfunction

    // Offers one byte at the falling edge, with random idle cycles first,
    // and holds it until a rising edge finds the input not stalled.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        now_ms   <= t;
        do @(posedge clk); while (in_stall);
        frame_byte(b, t);
        bytes_sent++;
    endtask

    // Writes the stale limit once the block has drained. Bytes that end no
    // line may still sit in the command queue, hence the short settle time.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_ms = value;
    endtask

    // Time step to the next byte: mostly within the limit, often right at
    // or just past it, and now and then a jump across the whole clock range.
    function automatic logic [TIME_W-1:0] next_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return $urandom_range(0, limit_ms);
        else if (pick < 67)
            return {16'd0, limit_ms};
        else if (pick < 77)
            return {16'd0, limit_ms} + 32'd1;
        else if (pick < 84)
            return {16'd0, limit_ms} + $urandom_range(2, 1000);
        else if (pick < 96)
            return '0;
        else
            return $urandom;
    endfunction

    task automatic send_stamped(input logic [BYTE_W-1:0] b);
        clock_ms = clock_ms + next_gap();
        send_byte(b, clock_ms);
    endtask

    // One well-formed line with random text and a few stray bytes, or a
    // burst of noise, or a bare line end.
    task automatic send_sequence();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 4)) send_stamped(BYTE_W'($urandom_range(0, 255)));
        end
        else if (pick < 17)
        begin
            send_stamped($urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 85)
                len = $urandom_range(13, 40);
            else if (pick < 93)
                len = $urandom_range(41, LINE_CAP);
            else
                len = $urandom_range(LINE_CAP, LINE_CAP + 7);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_stamped(BYTE_W'($urandom_range(0, 255)));
                send_stamped(BYTE_W'($urandom_range(PRINT_LOW, PRINT_HIGH)));
            end
            send_stamped($urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN);
        end
    endtask

    // Receiver: random stalls, or a long hold when the stimulus asks for one
    // so that the block backs up into its input.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(0, 99) < 29);
            end
        end
    end

    // Every accepted character is checked against the oldest expectation.
    initial
    begin
        char_slot_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character %h at index %0d", line_char, char_index);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (line_char !== want.ch)
                    begin
                        $error("line_char: expected %h, got %h", want.ch, line_char);
                        fail_count++;
                    end
                    if (char_index !== want.idx)
                    begin
                        $error("char_index: expected %0d, got %0d", want.idx, char_index);
                        fail_count++;
                    end
                    if (line_end !== want.last)
                    begin
                        $error("line_end: expected %b, got %b", want.last, line_end);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without a transaction on either
    // channel means the block has hung.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] phase_limit;
        int                 phase_start;
        int                 count_before;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed script, run with the stale limit left at its reset value.
        for (int r = 0; r < ROWS; r++)
        begin
            for (int k = 0; k < script[r].reps; k++)
            begin
                count_before = chars_predicted;
                send_byte(script[r].rx + k[BYTE_W-1:0], script[r].at_ms);
                if (script[r].typed)
                begin
                    if (chars_predicted != count_before + 1)
                    begin
                        $error("script row %0d: model gave %0d characters", r,
                               chars_predicted - count_before);
                        fail_count++;
                    end
                    else
                    begin
                        pending_chars[pending_chars.size() - 1] =
                            '{script[r].ch, script[r].ix, script[r].last};
                    end
                end
            end
        end
        clock_ms = script[ROWS-1].at_ms;

        // Random phases, each under its own stale limit.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_limit = 16'd0;
                1: phase_limit = 16'hFFFF;
                3: phase_limit = 16'd1;
                5: phase_limit = LIMIT_RESET;
                default: phase_limit = LIMIT_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_limit(phase_limit);
            steady = (p == 3);
            if (p == 4)
                clock_ms = 32'hFFFF_FFC0;
            if (p == 2)
            begin
                // Long output hold while a full line and more keep coming.
                hold_requests++;
                for (int k = 0; k < LINE_CAP; k++)
                    send_byte(BYTE_W'($urandom_range(PRINT_LOW, PRINT_HIGH)), clock_ms);
                send_byte(CH_NEWLINE, clock_ms);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_sequence();
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== text_line_framer_with_stale_timeout.f =====
sv/tlf_pkg.sv
sv/tlf_ram.sv
sv/tlf_cmd_queue.sv
sv/tlf_front.sv
sv/tlf_back.sv
sv/text_line_framer_with_stale_timeout.sv
test/text_line_framer_with_stale_timeout_test.sv
